[hw/rtl/smpscl_pkg.sv]
`timescale 1ns / 1ps

package smpscl_pkg;

	typedef enum logic [1:0] {
		OP_UPDATE    = 2'd0,
		OP_POWER_ON  = 2'd1,
		OP_POWER_OFF = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		REG_CURRENT_SETPOINT = 2'd0,
		REG_VOLTAGE_SETPOINT = 2'd1,
		REG_DRIVE_LIMIT      = 2'd2,
		REG_TRIP_LEVEL       = 2'd3
	} reg_idx_t;

	localparam int unsigned CFG_W   = 16;
	localparam int unsigned DRIVE_W = 16;
	localparam int unsigned STEP_W  = 8;
	localparam int unsigned ERR_SHIFT = 6;
	localparam int unsigned GAP_SHIFT = 8;

	localparam logic [CFG_W-1:0] TRIP_LEVEL_RST = 16'hFFFF;

	typedef struct packed {
		op_t         operation;
		logic [15:0] voltage_sample;
		logic [15:0] current_sample;
		logic [15:0] start_drive;
	} item_t;

	typedef struct packed {
		logic [15:0] drive;
		logic        enabled;
		logic        tripped;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] current_setpoint;
		logic [CFG_W-1:0] voltage_setpoint;
		logic [CFG_W-1:0] drive_limit;
		logic [CFG_W-1:0] trip_level;
	} cfg_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] drive_value;
		logic [STEP_W-1:0]  soft_step;
		logic               running;
	} state_t;

endpackage

[hw/rtl/smpscl_if.sv]
`timescale 1ns / 1ps

interface smpscl_item_if;
	import smpscl_pkg::*;

	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface smpscl_result_if;
	import smpscl_pkg::*;

	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/smpscl_core.sv]
`timescale 1ns / 1ps

module smpscl_core (
	input  smpscl_pkg::item_t  item,
	input  smpscl_pkg::cfg_t   cfg,
	input  smpscl_pkg::state_t cur_state,
	output smpscl_pkg::state_t next_state,
	output logic               tripped
);
	import smpscl_pkg::*;

	logic signed [16:0] err;
	logic signed [16:0] err_adj;
	logic signed [10:0] quot;
	logic signed [11:0] delta;
	logic signed [18:0] acc;
	logic [STEP_W-1:0]  step_n;
	logic               add_step;
	logic               integ;
	logic [15:0]        gap;

	always_comb begin
		err     = $signed({1'b0, cfg.current_setpoint}) - $signed({1'b0, item.current_sample});
		// round toward zero on negative error
		err_adj = err[16] ? err + 17'sd63 : err;
		quot    = err_adj[16:ERR_SHIFT];
		delta   = quot[10] ? {quot[10], quot} - 12'sd1 : {quot[10], quot} + 12'sd1;

		add_step = 1'b0;
		step_n   = cur_state.soft_step;
		if (cfg.voltage_setpoint != '0) begin
			if ((item.voltage_sample < cfg.voltage_setpoint) && !err[16] && (err != '0))
				add_step = 1'b1;
			else
				step_n = '0;
		end
		integ = (step_n == '0);

		acc = $signed({3'b000, cur_state.drive_value});
		if (add_step)
			acc = acc + $signed({10'd0, cur_state.soft_step, 1'b0});
		if (integ)
			acc = acc + {{7{delta[11]}}, delta};

		gap = cfg.voltage_setpoint - item.voltage_sample;

		next_state = cur_state;
		tripped    = 1'b0;
		case (item.operation)
			OP_UPDATE: begin
				if (cur_state.running) begin
					if (item.voltage_sample >= cfg.trip_level) begin
						next_state.running = 1'b0;
						tripped            = 1'b1;
					end else begin
						next_state.soft_step = step_n;
						if (acc[18])
							next_state.drive_value = '0;
						else if (acc[17:0] > {2'b00, cfg.drive_limit})
							next_state.drive_value = cfg.drive_limit;
						else
							next_state.drive_value = acc[15:0];
					end
				end
			end
			OP_POWER_ON: begin
				if (cfg.voltage_setpoint > item.voltage_sample) begin
					next_state.soft_step   = gap[15:GAP_SHIFT];
					next_state.drive_value = item.start_drive;
				end else begin
					next_state.soft_step   = '0;
					next_state.drive_value = cfg.drive_limit;
				end
				next_state.running = 1'b1;
			end
			OP_POWER_OFF: begin
				next_state.running = 1'b0;
			end
			default: begin
				next_state = cur_state;
			end
		endcase
	end

endmodule

[hw/rtl/smps_current_loop_soft_start.sv]
`timescale 1ns / 1ps

// channel  dir  handshake      beat
// sample   in   valid/ready    operation, voltage_sample, current_sample, start_drive
// result   out  valid/ready    drive, enabled, tripped
// cfg      in   cfg_we         cfg_index, cfg_data
//
// A beat is registered into item_s1; its result then loads into res_s2 on advance.
// One beat per cycle unless result stalls; loop state and result load in the same cycle.
// Reset clears loop state, both stage valids and config, but sets trip level to all ones.
// A stalled result holds the input stage; sample.ready drops only then.

module smps_current_loop_soft_start (
	input  logic                        clk,
	input  logic                        arst_n,
	smpscl_item_if.sink                 sample,
	smpscl_result_if.source             result,
	input  logic                        cfg_we,
	input  smpscl_pkg::reg_idx_t        cfg_index,
	input  logic [smpscl_pkg::CFG_W-1:0] cfg_data
);
	import smpscl_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_n;
	logic    tripped_n;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	assign advance      = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;

	assign result.valid   = valid_s2;
	assign result.payload = res_s2;

	smpscl_core u_core (
		.item       (item_s1),
		.cfg        (cfg_q),
		.cur_state  (state_q),
		.next_state (state_n),
		.tripped    (tripped_n)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.current_setpoint <= '0;
			cfg_q.voltage_setpoint <= '0;
			cfg_q.drive_limit      <= '0;
			cfg_q.trip_level       <= TRIP_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CURRENT_SETPOINT: cfg_q.current_setpoint <= cfg_data;
				REG_VOLTAGE_SETPOINT: cfg_q.voltage_setpoint <= cfg_data;
				REG_DRIVE_LIMIT:      cfg_q.drive_limit      <= cfg_data;
				REG_TRIP_LEVEL:       cfg_q.trip_level       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (sample.ready)
				valid_s1 <= sample.valid;
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_n;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid)
			item_s1 <= sample.payload;
		if (advance) begin
			res_s2.drive   <= state_n.drive_value;
			res_s2.enabled <= state_n.running;
			res_s2.tripped <= tripped_n;
		end
	end

endmodule

[test/smps_current_loop_soft_start_tb.sv]
`timescale 1ns / 1ps

module smps_current_loop_soft_start_tb;
	import smpscl_pkg::*;

	localparam int   ERR_DIV          = 1 << ERR_SHIFT;
	localparam int   HOLD_OFF_CYCLES  = 200;
	localparam int   CYCLE_LIMIT      = 200000;
	localparam int   DRAIN_CYCLES     = 8;
	localparam op_t  OP_RESERVED      = op_t'(2'd3);

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	reg_idx_t cfg_index;
	logic [CFG_W-1:0] cfg_data;

	smpscl_item_if   sample_ch ();
	smpscl_result_if result_ch ();

	smps_current_loop_soft_start u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cfg_t               loop_cfg;
	logic [DRIVE_W-1:0] loop_drive;
	logic [STEP_W-1:0]  loop_step;
	logic               loop_on;

	result_t pending_results[$];
	result_t want;
	int      fail_count = 0;
	int      cycle_count = 0;
	int      src_idle_pct = 0;
	int      snk_idle_pct = 0;
	bit      hold_off_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic result_t advance_loop(item_t it);
		int      err;
		int      acc;
		int      q;
		result_t r;
		r.tripped = 1'b0;
		case (it.operation)
			OP_UPDATE: begin
				if (loop_on) begin
					if (it.voltage_sample >= loop_cfg.trip_level) begin
						loop_on = 1'b0;
						r.tripped = 1'b1;
					end else begin
						err = int'(loop_cfg.current_setpoint) - int'(it.current_sample);
						acc = int'(loop_drive);
						if (loop_cfg.voltage_setpoint != '0) begin
							if (it.voltage_sample < loop_cfg.voltage_setpoint && err > 0)
								acc += 2 * int'(loop_step);
							else
								loop_step = '0;
						end
						if (loop_step == '0) begin
							q = err / ERR_DIV;
							acc += q + ((q >= 0) ? 1 : -1);
						end
						if (acc < 0)
							acc = 0;
						if (acc > int'(loop_cfg.drive_limit))
							acc = int'(loop_cfg.drive_limit);
						loop_drive = DRIVE_W'(acc);
					end
				end
			end
			OP_POWER_ON: begin
				if (loop_cfg.voltage_setpoint > it.voltage_sample) begin
					loop_step = STEP_W'((loop_cfg.voltage_setpoint - it.voltage_sample) >> GAP_SHIFT);
					loop_drive = it.start_drive;
				end else begin
					loop_step = '0;
					loop_drive = loop_cfg.drive_limit;
				end
				loop_on = 1'b1;
			end
			OP_POWER_OFF: begin
				loop_on = 1'b0;
			end
			default: begin
			end
		endcase
		r.drive = loop_drive;
		r.enabled = loop_on;
		return r;
	endfunction

	always @(posedge clk) begin
		if (sample_ch.valid && sample_ch.ready)
			pending_results.push_back(advance_loop(sample_ch.payload));
	end

	always @(posedge clk) begin
		if (result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation: drive %0h enabled %0b tripped %0b",
					result_ch.payload.drive, result_ch.payload.enabled, result_ch.payload.tripped);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_ch.payload.drive !== want.drive) begin
					$error("drive: expected %0h, actual %0h", want.drive, result_ch.payload.drive);
					fail_count++;
				end
				if (result_ch.payload.enabled !== want.enabled) begin
					$error("enabled: expected %0b, actual %0b", want.enabled,
						result_ch.payload.enabled);
					fail_count++;
				end
				if (result_ch.payload.tripped !== want.tripped) begin
					$error("tripped: expected %0b, actual %0b", want.tripped,
						result_ch.payload.tripped);
					fail_count++;
				end
			end
		end
	end

	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("smps_current_loop_soft_start regression: fail");
			$finish;
		end
	end

	task automatic send_beat(input op_t op, input logic [15:0] v, input logic [15:0] cur,
		input logic [15:0] start);
		item_t it;
		it.operation = op;
		it.voltage_sample = v;
		it.current_sample = cur;
		it.start_drive = start;
		while ($urandom_range(99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.payload <= it;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_config(input cfg_t c);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_CURRENT_SETPOINT;
		cfg_data <= c.current_setpoint;
		@(posedge clk);
		cfg_index <= REG_VOLTAGE_SETPOINT;
		cfg_data <= c.voltage_setpoint;
		@(posedge clk);
		cfg_index <= REG_DRIVE_LIMIT;
		cfg_data <= c.drive_limit;
		@(posedge clk);
		cfg_index <= REG_TRIP_LEVEL;
		cfg_data <= c.trip_level;
		@(posedge clk);
		cfg_we <= 1'b0;
		loop_cfg = c;
	endtask

	function automatic logic [15:0] pick_setting();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.current_setpoint = pick_setting();
		c.voltage_setpoint = pick_setting();
		c.drive_limit = pick_setting();
		case ($urandom_range(5))
			0: c.trip_level = 16'hFFFF;
			1: c.trip_level = 16'($urandom);
			default: c.trip_level = 16'($urandom_range(16'hFFFF, 16'h8000));
		endcase
		return c;
	endfunction

	task automatic send_random_beat();
		int               pick;
		logic [15:0]      v;
		logic [15:0]      cur;
		pick = $urandom_range(99);
		case ($urandom_range(7))
			0: v = 16'($urandom);
			7: v = 16'(int'(loop_cfg.trip_level) - int'($urandom_range(4)));
			default: v = 16'($urandom_range(32'(loop_cfg.voltage_setpoint)));
		endcase
		if ($urandom_range(3) == 0)
			cur = 16'($urandom);
		else
			cur = 16'(int'(loop_cfg.current_setpoint) + int'($urandom_range(4096)) - 2048);
		if (pick < 85)
			send_beat(OP_UPDATE, v, cur, 16'($urandom));
		else if (pick < 92)
			send_beat(OP_POWER_ON, 16'($urandom_range(32'(loop_cfg.voltage_setpoint))), cur,
				16'($urandom));
		else if (pick < 97)
			send_beat(OP_POWER_OFF, v, cur, 16'($urandom));
		else
			send_beat(OP_RESERVED, v, cur, 16'($urandom));
	endtask

	task automatic run_random_sequence(output int n);
		set_config(random_cfg());
		send_beat(OP_POWER_ON, 16'($urandom_range(32'(loop_cfg.voltage_setpoint))),
			16'($urandom), 16'($urandom));
		n = $urandom_range(30, 10);
		repeat (n) send_random_beat();
		n++;
	endtask

	task automatic test_disabled_and_reserved();
		send_beat(OP_UPDATE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_beat(OP_RESERVED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_beat(OP_POWER_OFF, 16'h0000, 16'h0000, 16'h0000);
	endtask

	task automatic test_soft_start_ramp();
		set_config('{16'h8000, 16'hC000, 16'hFFFF, 16'hF000});
		send_beat(OP_POWER_ON, 16'h0000, 16'h0000, 16'h0100);
		send_beat(OP_UPDATE, 16'h1000, 16'h0000, 16'h0000);
		send_beat(OP_UPDATE, 16'h1000, 16'h0000, 16'h0000);
		send_beat(OP_UPDATE, 16'h1000, 16'hFFFF, 16'h0000);
		send_beat(OP_UPDATE, 16'h1000, 16'h8001, 16'h0000);
		send_beat(OP_UPDATE, 16'h1000, 16'h8040, 16'h0000);
		send_beat(OP_UPDATE, 16'h1000, 16'h803F, 16'h0000);
	endtask

	task automatic test_integrator_and_clamp();
		send_beat(OP_POWER_ON, 16'hC000, 16'h0000, 16'h0000);
		send_beat(OP_UPDATE, 16'h0000, 16'h0000, 16'h0000);
		set_config('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
		send_beat(OP_POWER_ON, 16'h0000, 16'h0000, 16'hFFFF);
		send_beat(OP_UPDATE, 16'h0000, 16'h0000, 16'h0000);
		send_beat(OP_UPDATE, 16'h0000, 16'hFFFF, 16'h0000);
	endtask

	task automatic test_trip_and_power_off();
		set_config('{16'h8000, 16'hC000, 16'hFFFF, 16'hF000});
		send_beat(OP_POWER_ON, 16'h0000, 16'h0000, 16'h1234);
		send_beat(OP_UPDATE, 16'hF000, 16'h0000, 16'h0000);
		send_beat(OP_UPDATE, 16'h0000, 16'h0000, 16'h0000);
		send_beat(OP_POWER_ON, 16'hFFFF, 16'h0000, 16'h1234);
		send_beat(OP_UPDATE, 16'hEFFF, 16'h7FFF, 16'h0000);
		send_beat(OP_POWER_OFF, 16'h0000, 16'h0000, 16'h0000);
		send_beat(OP_UPDATE, 16'h0000, 16'h0000, 16'h0000);
	endtask

	task automatic test_step_held_without_voltage_loop();
		set_config('{16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF});
		send_beat(OP_POWER_ON, 16'h0000, 16'h0000, 16'h0000);
		set_config('{16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFF});
		send_beat(OP_UPDATE, 16'h1234, 16'h0000, 16'h0000);
		send_beat(OP_UPDATE, 16'hFFFE, 16'hFFFF, 16'h0000);
		send_beat(OP_POWER_OFF, 16'h0000, 16'h0000, 16'h0000);
	endtask

	task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items);
		int sent;
		int n;
		sent = 0;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		while (sent < n_items) begin
			run_random_sequence(n);
			sent += n;
		end
	endtask

	task automatic test_backpressure();
		set_config(random_cfg());
		src_idle_pct = 0;
		snk_idle_pct = 0;
		send_beat(OP_POWER_ON, 16'($urandom_range(32'(loop_cfg.voltage_setpoint))),
			16'($urandom), 16'($urandom));
		hold_off_req = 1'b1;
		repeat (40) send_random_beat();
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CURRENT_SETPOINT;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.payload = '0;
		loop_cfg = '{16'h0000, 16'h0000, 16'h0000, TRIP_LEVEL_RST};
		loop_drive = '0;
		loop_step = '0;
		loop_on = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 10;
		snk_idle_pct = 53;
		test_disabled_and_reserved();
		test_soft_start_ramp();
		test_integrator_and_clamp();
		test_trip_and_power_off();
		test_step_held_without_voltage_loop();
		test_random_traffic(10, 53, 140);
		test_backpressure();
		test_random_traffic(53, 10, 140);
		test_random_traffic(0, 0, 140);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("smps_current_loop_soft_start regression: pass");
		end else begin
			$display("smps_current_loop_soft_start regression: fail");
		end
		$finish;
	end

endmodule

[sim.f]
hw/rtl/smpscl_pkg.sv
hw/rtl/smpscl_if.sv
hw/rtl/smpscl_core.sv
hw/rtl/smps_current_loop_soft_start.sv
test/smps_current_loop_soft_start_tb.sv
